### src/dvbf_pkg.sv
// Package for the dynamic vertex batch former.
// Holds sizes, configuration indexes, the controller state type and the saturating add; no dependencies.
package dvbf_pkg;

    localparam int SET_CAPACITY = 256;
    localparam int INDEX_BITS   = 32;
    localparam int ADDR_W       = $clog2(SET_CAPACITY);
    localparam int CNT_W        = ADDR_W + 1;
    localparam int SUM_W        = 32;

    localparam logic [1:0] CFG_INDEX_LIMIT  = 2'd0;
    localparam logic [1:0] CFG_VERTEX_LIMIT = 2'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_INSERT,
        ST_DONE
    } state_t;

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {{(SUM_W + 1 - CNT_W){1'b0}}, b};
        sat_add = s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
    endfunction

endpackage

### src/dynamic_vertex_batch_former.sv
// Top level of the dynamic vertex batch former: controller, counters, output register.
// Depends on dvbf_pkg and dvbf_vertex_ram.
//
// Usage: one triangle (three vertex indices and a last flag) is accepted on the
// input channel when in_valid is high and in_stall is low. One result comes out
// on the output channel for each triangle, taken when out_valid is high and
// out_stall is low. The configuration port writes batch_index_limit (index 0)
// or vertex_limit (index 1) whenever cfg_write is high; other indexes are ignored.
// An accepted item passes through the scan, decision, insert and done states:
// the store is scanned one entry a cycle through its single read port, over
// the N distinct vertices already in the batch; then one decision step,
// three insert steps and the load of the output register follow.
// The block works on one item at a time and takes the next only after it
// has returned to idle. A new item may be accepted while the previous result
// still waits in the output register; if the receiver keeps stalling, the
// block holds its finished result and stalls the input.
// Reset empties the batch and the total and loads the limits with 96 and 32.
// The store needs no clearing, as only the first seen_count entries are read.
module dynamic_vertex_batch_former (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [11:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] first_index,
    input  logic [31:0] second_index,
    input  logic [31:0] third_index,
    input  logic        last_triangle,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        batch_restarted,
    output logic [1:0]  new_vertices,
    output logic [8:0]  batch_vertices,
    output logic [31:0] unique_total,
    output logic        stream_done
);

    localparam int IB = dvbf_pkg::INDEX_BITS;
    localparam int CW = dvbf_pkg::CNT_W;
    localparam int AW = dvbf_pkg::ADDR_W;

    dvbf_pkg::state_t state_reg, state_next;

    logic [11:0]   index_limit_reg;
    logic [8:0]    vertex_limit_reg;
    logic [IB-1:0] v_reg [3];
    logic          last_reg;
    logic [2:0]    found_reg, found_next;
    logic [CW-1:0] seen_reg, seen_next;
    logic [11:0]   bic_reg, bic_next;
    logic [31:0]   closed_reg, closed_next;
    logic [CW-1:0] issue_reg, issue_next;
    logic          pend_reg, pend_next;
    logic [1:0]    ins_reg, ins_next;
    logic [2:0]    is_new_reg, is_new_next;
    logic          restart_reg, restart_next;
    logic [1:0]    added_reg, added_next;

    logic          accept;
    logic          out_load;
    logic          rd_en, wr_en;
    logic [IB-1:0] rd_data;
    logic [IB-1:0] wr_data;

    logic [12:0]   bic_plus3;
    logic [8:0]    limit_eff;
    logic [1:0]    to_add;
    logic [9:0]    seen_plus;
    logic          restart_now;
    logic [2:0]    eff_found;

    dvbf_vertex_ram u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (seen_reg[AW-1:0]),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (issue_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    assign accept   = in_valid && !in_stall;
    assign out_load = (state_reg == dvbf_pkg::ST_DONE) && (!out_valid || !out_stall);
    assign wr_data  = v_reg[ins_reg];

    always_comb
    begin
        bic_plus3 = {1'b0, bic_reg} + 13'd3;
        limit_eff = (vertex_limit_reg > 9'(dvbf_pkg::SET_CAPACITY))
                    ? 9'(dvbf_pkg::SET_CAPACITY) : vertex_limit_reg;
        to_add    = 2'(!found_reg[0]) + 2'(!found_reg[1]) + 2'(!found_reg[2]);
        seen_plus = {{(10 - CW){1'b0}}, seen_reg} + {8'd0, to_add};
        restart_now = (bic_plus3 > {1'b0, index_limit_reg})
                      || (seen_plus >= {1'b0, limit_eff});
        eff_found = restart_now ? 3'b000 : found_reg;
    end

    always_comb
    begin
        state_next   = state_reg;
        in_stall     = 1'b1;
        rd_en        = 1'b0;
        wr_en        = 1'b0;
        found_next   = found_reg;
        seen_next    = seen_reg;
        bic_next     = bic_reg;
        closed_next  = closed_reg;
        issue_next   = issue_reg;
        pend_next    = 1'b0;
        ins_next     = ins_reg;
        is_new_next  = is_new_reg;
        restart_next = restart_reg;
        added_next   = added_reg;
        case (state_reg)
            dvbf_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    found_next = 3'b000;
                    issue_next = '0;
                    state_next = dvbf_pkg::ST_SCAN;
                end
            end
            dvbf_pkg::ST_SCAN:
            begin
                // One entry is read per cycle; it is compared in the next cycle.
                if (issue_reg < seen_reg)
                begin
                    rd_en      = 1'b1;
                    pend_next  = 1'b1;
                    issue_next = issue_reg + CW'(1);
                end
                if (pend_reg)
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        if (rd_data == v_reg[k])
                        begin
                            found_next[k] = 1'b1;
                        end
                    end
                end
                if (!(issue_reg < seen_reg))
                begin
                    state_next = dvbf_pkg::ST_DECIDE;
                end
            end
            dvbf_pkg::ST_DECIDE:
            begin
                restart_next = restart_now;
                if (restart_now)
                begin
                    closed_next = dvbf_pkg::sat_add(closed_reg, seen_reg);
                    seen_next   = '0;
                    bic_next    = '0;
                end
                // A corner that repeats an earlier corner was inserted by it.
                is_new_next[0] = !eff_found[0];
                is_new_next[1] = !eff_found[1] && (v_reg[1] != v_reg[0]);
                is_new_next[2] = !eff_found[2] && (v_reg[2] != v_reg[0])
                                 && (v_reg[2] != v_reg[1]);
                added_next = '0;
                ins_next   = '0;
                state_next = dvbf_pkg::ST_INSERT;
            end
            dvbf_pkg::ST_INSERT:
            begin
                if (is_new_reg[ins_reg])
                begin
                    wr_en      = 1'b1;
                    seen_next  = seen_reg + CW'(1);
                    added_next = added_reg + 2'd1;
                end
                if (ins_reg == 2'd2)
                begin
                    bic_next   = bic_reg + 12'd3;
                    state_next = dvbf_pkg::ST_DONE;
                end
                else
                begin
                    ins_next = ins_reg + 2'd1;
                end
            end
            dvbf_pkg::ST_DONE:
            begin
                if (out_load)
                begin
                    if (last_reg)
                    begin
                        seen_next   = '0;
                        bic_next    = '0;
                        closed_next = '0;
                    end
                    state_next = dvbf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dvbf_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= dvbf_pkg::ST_IDLE;
            index_limit_reg  <= 12'd96;
            vertex_limit_reg <= 9'd32;
            seen_reg         <= '0;
            bic_reg          <= '0;
            closed_reg       <= '0;
            pend_reg         <= 1'b0;
            out_valid        <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            seen_reg   <= seen_next;
            bic_reg    <= bic_next;
            closed_reg <= closed_next;
            pend_reg   <= pend_next;
            if (cfg_write && cfg_index == dvbf_pkg::CFG_INDEX_LIMIT)
            begin
                index_limit_reg <= cfg_data;
            end
            if (cfg_write && cfg_index == dvbf_pkg::CFG_VERTEX_LIMIT)
            begin
                vertex_limit_reg <= cfg_data[8:0];
            end
            if (out_load)
            begin
                out_valid <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        found_reg   <= found_next;
        issue_reg   <= issue_next;
        ins_reg     <= ins_next;
        is_new_reg  <= is_new_next;
        restart_reg <= restart_next;
        added_reg   <= added_next;
        if (accept)
        begin
            v_reg[0] <= first_index[IB-1:0];
            v_reg[1] <= second_index[IB-1:0];
            v_reg[2] <= third_index[IB-1:0];
            last_reg <= last_triangle;
        end
        if (out_load)
        begin
            batch_restarted <= restart_reg;
            new_vertices    <= added_reg;
            batch_vertices  <= 9'(seen_reg);
            unique_total    <= dvbf_pkg::sat_add(closed_reg, seen_reg);
            stream_done     <= last_reg;
        end
    end

`ifndef NO_ASSERTIONS
    a_seen_bound: assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg <= CW'(dvbf_pkg::SET_CAPACITY))
        else $error("vertex set grew past its capacity");
    a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dvbf_pkg::ST_SCAN) |-> !wr_en)
        else $error("store written during a scan");
    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == dvbf_pkg::ST_SCAN))
        else $error("accepted item did not start a scan");
    a_load_once: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (state_reg == dvbf_pkg::ST_IDLE) && out_valid)
        else $error("result load did not return to idle");
`endif

endmodule

### src/dvbf_vertex_ram.sv
// Vertex store of the batch former: one write port, one registered read port.
// Depends on dvbf_pkg for depth and width.
module dvbf_vertex_ram (
    input  logic                             clk,
    input  logic                             wr_en,
    input  logic [dvbf_pkg::ADDR_W-1:0]      wr_addr,
    input  logic [dvbf_pkg::INDEX_BITS-1:0]  wr_data,
    input  logic                             rd_en,
    input  logic [dvbf_pkg::ADDR_W-1:0]      rd_addr,
    output logic [dvbf_pkg::INDEX_BITS-1:0]  rd_data
);

    logic [dvbf_pkg::INDEX_BITS-1:0] mem [dvbf_pkg::SET_CAPACITY];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
